[src/fifo_expiring_blob_cache_macros.svh]
// Assertion helpers shared by the cache RTL
`ifndef FIFO_EXPIRING_BLOB_CACHE_MACROS_SVH
`define FIFO_EXPIRING_BLOB_CACHE_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define FEC_ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a plain invariant on every rising clock edge outside reset
`define FEC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

[src/fecache_pkg.sv]
package fecache_pkg;

   localparam int DEF_ENTRIES  = 64;
   localparam int DEF_KEY_BITS = 32;
   localparam int KEY_W        = 32;
   localparam int TIME_W       = 32;
   localparam int SIZE_W       = 24;
   localparam int HANDLE_W     = 32;
   localparam int CNT_W        = 32;
   localparam int HELD_W       = 7;
   localparam int REQ_W        = 128;
   localparam int RSP_W        = 264;
   localparam int CSR_IDX_W    = 2;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_MAX_ENTRIES = 2'd0,
      CSR_MAX_BYTES   = 2'd1,
      CSR_MAX_AGE     = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_APPLY,
      S_EVICT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   size;
      logic [TIME_W-1:0]   stamp;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic compare;
      logic shift_hole;
      logic shift_all;
      logic load;
   } cell_cmd_type;

endpackage

[src/fecache_cell.sv]
module fecache_cell #(
   parameter int INDEX    = 0,
   parameter int KEY_BITS = 32,
   parameter int CW       = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fecache_pkg::cell_cmd_type cmd,
   input  logic [CW-1:0]            count,
   input  logic [KEY_BITS-1:0]      cmp_key,
   input  fecache_pkg::entry_type   new_entry,
   input  logic [KEY_BITS-1:0]      up_key,
   input  fecache_pkg::entry_type   up_entry,
   input  logic                     hole_in,
   output logic [KEY_BITS-1:0]      key,
   output fecache_pkg::entry_type   entry,
   output logic                     hit,
   output logic                     hole_out
);
   import fecache_pkg::*;

   logic [KEY_BITS-1:0] key_ff, key_in;
   entry_type           entry_ff, entry_in;
   logic                match_ff, match_in;
   logic                valid;

   // Cells below the fill count hold live entries, oldest at index zero
   assign valid    = count > CW'(INDEX);
   assign hole_out = hole_in | match_ff;

   // Compare key, drop behind a removed cell, load the new entry at the tail
   always_comb begin
      key_in   = key_ff;
      entry_in = entry_ff;
      match_in = match_ff;
      if (cmd.compare) begin
         match_in = valid && (key_ff == cmp_key);
      end
      if (cmd.load && (count == CW'(INDEX))) begin
         key_in   = cmp_key;
         entry_in = new_entry;
      end else if (cmd.shift_all || (cmd.shift_hole && hole_out)) begin
         key_in   = up_key;
         entry_in = up_entry;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      entry_ff <= entry_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign key   = key_ff;
   assign entry = entry_ff;
   assign hit   = match_ff;

endmodule

[src/fifo_expiring_blob_cache.sv]
// Keyed blob descriptor cache with insertion-order eviction and entry age.
// req_ channel: one operation per item (lookup, insert, remove, clear).
// rsp_ channel: exactly one result item per request, in request order,
// carrying lookup hit data, insert acceptance, occupancy and all counters.
// csr_ channel: register writes (0 max entries, 1 max bytes, 2 max age),
// always ready, to be issued only while the cache is idle.
// After accept an item passes the match, apply and done states; an insert
// that is not refused also passes the evict state, which evicts one entry
// per step until the new one fits, then loads it. One item is in work at a
// time: the sequencer returns to idle before it accepts the next.
// Entries live in a chain of cells ordered oldest first; a remove or an
// eviction shifts the younger cells down by one position together, and
// each eviction is one step of the sequencer's evict state.
// Reset empties the table and clears every counter and limit.
// A stalled rsp_tready holds the result; the next item may be accepted and
// worked on, finishing only once the output register is free.
module fifo_expiring_blob_cache #(
   parameter int ENTRIES  = fecache_pkg::DEF_ENTRIES,
   parameter int KEY_BITS = fecache_pkg::DEF_KEY_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // op[1:0], key[33:2], now[65:34], blob_size[89:66], blob_handle[121:90]
   input  logic [fecache_pkg::REQ_W-1:0]    req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // found[0], out_handle[32:1], out_size[56:33], accepted[57],
   // entries_held[64:58], bytes_held[96:65], lookup_count[128:97],
   // hit_count[160:129], miss_count[192:161], insert_count[224:193],
   // remove_count[256:225]
   output logic [fecache_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fecache_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                      csr_data
);
   import fecache_pkg::*;
   `include "fifo_expiring_blob_cache_macros.svh"

   localparam int CW = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]    bytes_ff, bytes_in;
   logic [CNT_W-1:0]    lk_ff, lk_in, hit_ff, hit_in, miss_ff, miss_in;
   logic [CNT_W-1:0]    ins_ff, ins_in, rm_ff, rm_in;
   logic [HELD_W-1:0]   max_entries_ff;
   logic [31:0]         max_bytes_ff, max_age_ff;
   logic                any_ff, any_in, acc_ff, acc_in;
   entry_type           sel_ff, sel_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   cell_cmd_type        cmd;
   logic [KEY_BITS-1:0] cmp_key;
   entry_type           new_entry;
   logic [KEY_BITS-1:0] cell_key   [ENTRIES];
   entry_type           cell_entry [ENTRIES];
   logic                cell_hit   [ENTRIES];
   logic                hole       [ENTRIES+1];
   entry_type           sel_entry;
   logic                any_hit;
   logic [CW-1:0]       cap;
   logic                refused, need_evict, found;
   logic [TIME_W-1:0]   age;

   assign cmp_key   = KEY_BITS'(key_ff);
   assign new_entry = '{size: size_ff, stamp: now_ff, handle: handle_ff};
   assign hole[0]   = 1'b0;

   // Row of cells, each taking its younger neighbor on a shift
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == ENTRIES - 1) begin : g_last
         fecache_cell #(.INDEX(g), .KEY_BITS(KEY_BITS), .CW(CW)) u_cell (
            .clock, .reset, .cmd, .count(count_ff), .cmp_key, .new_entry,
            .up_key('0), .up_entry('0), .hole_in(hole[g]),
            .key(cell_key[g]), .entry(cell_entry[g]), .hit(cell_hit[g]),
            .hole_out(hole[g+1]));
      end else begin : g_mid
         fecache_cell #(.INDEX(g), .KEY_BITS(KEY_BITS), .CW(CW)) u_cell (
            .clock, .reset, .cmd, .count(count_ff), .cmp_key, .new_entry,
            .up_key(cell_key[g+1]), .up_entry(cell_entry[g+1]), .hole_in(hole[g]),
            .key(cell_key[g]), .entry(cell_entry[g]), .hit(cell_hit[g]),
            .hole_out(hole[g+1]));
      end
   end

   // Gather the single matching cell (keys are unique in the table)
   always_comb begin
      sel_entry = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (cell_hit[i]) begin
            sel_entry = sel_entry | cell_entry[i];
         end
      end
   end
   assign any_hit = hole[ENTRIES];

   // Effective count limit and insert checks
   always_comb begin
      if (32'(max_entries_ff) > 32'(ENTRIES)) begin
         cap = CW'(ENTRIES);
      end else begin
         cap = CW'(max_entries_ff);
      end
   end
   assign refused = (32'(size_ff) > max_bytes_ff) || (max_bytes_ff == '0) ||
                    (cap == '0);
   assign need_evict = (count_ff != '0) &&
      (({1'b0, count_ff} + (CW+1)'(1) > {1'b0, cap}) ||
       ({1'b0, bytes_ff} + 33'(size_ff) > {1'b0, max_bytes_ff}));
   assign age   = now_ff - sel_ff.stamp;
   assign found = any_ff && (age <= max_age_ff);

   // Sequencer: next state, cell commands, counters and result
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      size_in      = size_ff;
      handle_in    = handle_ff;
      count_in     = count_ff;
      bytes_in     = bytes_ff;
      lk_in        = lk_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      ins_in       = ins_ff;
      rm_in        = rm_ff;
      any_in       = any_ff;
      acc_in       = acc_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in     = op_type'(req_tdata[1:0]);
               key_in    = req_tdata[33:2];
               now_in    = req_tdata[65:34];
               size_in   = req_tdata[89:66];
               handle_in = req_tdata[121:90];
               any_in    = 1'b0;
               acc_in    = 1'b0;
               state_in  = S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.compare = 1'b1;
            state_in    = S_APPLY;
         end
         S_APPLY: begin
            state_in = S_DONE;
            unique case (op_ff) inside
               OP_LOOKUP: begin
                  any_in = any_hit;
                  sel_in = sel_entry;
               end
               OP_INSERT, OP_REMOVE: begin
                  if (!(op_ff == OP_INSERT && refused)) begin
                     if (any_hit) begin
                        cmd.shift_hole = 1'b1;
                        count_in       = count_ff - CW'(1);
                        bytes_in       = bytes_ff - 32'(sel_entry.size);
                     end
                     if (op_ff == OP_INSERT) begin
                        state_in = S_EVICT;
                     end
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
                  bytes_in = '0;
               end
               default: ;
            endcase
         end
         S_EVICT: begin
            if (need_evict) begin
               cmd.shift_all = 1'b1;
               count_in      = count_ff - CW'(1);
               bytes_in      = bytes_ff - 32'(cell_entry[0].size);
            end else begin
               cmd.load = 1'b1;
               count_in = count_ff + CW'(1);
               bytes_in = bytes_ff + 32'(size_ff);
               acc_in   = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               unique case (op_ff)
                  OP_LOOKUP: begin
                     lk_in = lk_ff + 32'd1;
                     if (found) hit_in = hit_ff + 32'd1;
                     else miss_in = miss_ff + 32'd1;
                  end
                  OP_INSERT: if (acc_ff) ins_in = ins_ff + 32'd1;
                  OP_REMOVE: rm_in = rm_ff + 32'd1;
                  OP_CLEAR: begin
                     lk_in   = '0;
                     hit_in  = '0;
                     miss_in = '0;
                     ins_in  = '0;
                  end
                  default: ;
               endcase
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, rm_in, ins_in, miss_in, hit_in, lk_in,
                               bytes_ff, HELD_W'(count_ff), acc_ff,
                               found ? sel_ff.size : '0,
                               found ? sel_ff.handle : '0, found};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold payload, reset control and counters
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      now_ff      <= now_in;
      size_ff     <= size_in;
      handle_ff   <= handle_in;
      sel_ff      <= sel_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         bytes_ff       <= '0;
         lk_ff          <= '0;
         hit_ff         <= '0;
         miss_ff        <= '0;
         ins_ff         <= '0;
         rm_ff          <= '0;
         any_ff         <= 1'b0;
         acc_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_entries_ff <= '0;
         max_bytes_ff   <= '0;
         max_age_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
         lk_ff        <= lk_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         ins_ff       <= ins_in;
         rm_ff        <= rm_in;
         any_ff       <= any_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MAX_ENTRIES: max_entries_ff <= csr_data[HELD_W-1:0];
               CSR_MAX_BYTES:   max_bytes_ff   <= csr_data;
               CSR_MAX_AGE:     max_age_ff     <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `FEC_ASSERT_ALWAYS(a_count_max, clock, reset, 32'(count_ff) <= 32'(ENTRIES),
      "fill count above table size")
   `FEC_ASSERT_IMPL(a_empty_bytes, clock, reset,
      (count_ff == '0) |-> (bytes_ff == '0), "bytes held with empty table")
   `FEC_ASSERT_IMPL(a_accept_match, clock, reset,
      (req_tvalid && req_tready) |=> (state_ff == S_MATCH), "accept did not start match")
   `FEC_ASSERT_IMPL(a_evict_nonempty, clock, reset,
      cmd.shift_all |-> (count_ff != '0), "eviction from empty table")

endmodule

[verif/fifo_expiring_blob_cache_tb.sv]
module fifo_expiring_blob_cache_tb;
   import fecache_pkg::*;

   localparam int SLOTS = 64;

   typedef struct packed {
      logic [31:0] handle;
      logic [23:0] size;
      logic [31:0] now;
      logic [31:0] key;
      op_type      op;
   } cache_req_type;

   typedef struct {
      logic        found;
      logic [31:0] handle;
      logic [23:0] size;
      logic        accepted;
      logic [6:0]  entries;
      logic [31:0] bytes;
      logic [31:0] lookups;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] inserts;
      logic [31:0] removes;
   } cache_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   fifo_expiring_blob_cache uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // shadow table: slots in insertion order, oldest first
   logic [31:0] sh_key[$];
   logic [23:0] sh_size[$];
   logic [31:0] sh_time[$];
   logic [31:0] sh_handle[$];
   logic [31:0] lim_bytes, lim_age;
   logic [6:0]  lim_entries;
   logic [31:0] held_bytes, n_lookups, n_hits, n_misses, n_inserts, n_removes;

   cache_req_type pending_reqs[$];
   cache_rsp_type expected_rsps[$];
   int errors = 0;
   int stall_hold = 0;
   logic stall_ready = 1;
   logic [31:0] clock_now = 0;

   task automatic report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   function automatic int find_key(logic [31:0] k);
      foreach (sh_key[i]) if (sh_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void drop_entry(int i);
      held_bytes -= sh_size[i];
      sh_key.delete(i); sh_size.delete(i); sh_time.delete(i); sh_handle.delete(i);
   endfunction

   // compute the result of one operation and advance the shadow state
   function automatic cache_rsp_type cache_step(cache_req_type r);
      cache_rsp_type o;
      int s;
      int cap;
      o = '{default: 0};
      case (r.op)
         OP_LOOKUP: begin
            n_lookups++;
            s = find_key(r.key);
            if (s >= 0 && (r.now - sh_time[s]) <= lim_age) begin
               o.found = 1; o.handle = sh_handle[s]; o.size = sh_size[s];
               n_hits++;
            end else n_misses++;
         end
         OP_INSERT: begin
            cap = lim_entries > SLOTS ? SLOTS : lim_entries;
            if (!(r.size > lim_bytes || lim_bytes == 0 || cap == 0)) begin
               s = find_key(r.key);
               if (s >= 0) drop_entry(s);
               while (sh_key.size() > 0 && sh_key.size() + 1 > cap) drop_entry(0);
               while (sh_key.size() > 0 && {32'd0, held_bytes} + r.size > {32'd0, lim_bytes})
                  drop_entry(0);
               sh_key.push_back(r.key); sh_size.push_back(r.size);
               sh_time.push_back(r.now); sh_handle.push_back(r.handle);
               held_bytes += r.size;
               n_inserts++;
               o.accepted = 1;
            end
         end
         OP_REMOVE: begin
            s = find_key(r.key);
            if (s >= 0) drop_entry(s);
            n_removes++;
         end
         default: begin
            sh_key.delete(); sh_size.delete(); sh_time.delete(); sh_handle.delete();
            held_bytes = 0; n_lookups = 0; n_hits = 0; n_misses = 0; n_inserts = 0;
         end
      endcase
      o.entries = 7'(sh_key.size()); o.bytes = held_bytes;
      o.lookups = n_lookups; o.hits = n_hits; o.misses = n_misses;
      o.inserts = n_inserts; o.removes = n_removes;
      return o;
   endfunction

   function automatic int gap_len();
      int p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // driver: present pending items, predict on acceptance
   int send_gap = 0;
   logic send_hold = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(cache_step(cache_req_type'(req_tdata[121:0])));
            void'(pending_reqs.pop_front());
            send_gap <= gap_len();
         end
         if (req_tvalid && !req_tready) begin
            // keep offering
         end else if (send_hold || pending_reqs.size() == 0) begin
            req_tvalid <= 0;
         end else if (send_gap > 0 && !(req_tvalid && req_tready)) begin
            req_tvalid <= 0;
            send_gap <= send_gap - 1;
         end else if (req_tvalid && req_tready && gap_len() > 0) begin
            req_tvalid <= 0;
         end else begin
            req_tvalid <= 1;
            req_tdata <= {6'd0, pending_reqs[0]};
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_tready <= 0;
      end else if (!stall_ready) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0 ? 0 : 1);
      end
   end

   // monitor: check each result against the oldest prediction
   always @(posedge clock) begin
      cache_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) report("result with none expected");
         else begin
            e = expected_rsps.pop_front();
            if (rsp_tdata[0] !== e.found) report("found");
            if (rsp_tdata[32:1] !== e.handle) report("out_handle");
            if (rsp_tdata[56:33] !== e.size) report("out_size");
            if (rsp_tdata[57] !== e.accepted) report("accepted");
            if (rsp_tdata[64:58] !== e.entries) report("entries_held");
            if (rsp_tdata[96:65] !== e.bytes) report("bytes_held");
            if (rsp_tdata[128:97] !== e.lookups) report("lookup_count");
            if (rsp_tdata[160:129] !== e.hits) report("hit_count");
            if (rsp_tdata[192:161] !== e.misses) report("miss_count");
            if (rsp_tdata[224:193] !== e.inserts) report("insert_count");
            if (rsp_tdata[256:225] !== e.removes) report("remove_count");
         end
      end
   end

   function automatic cache_req_type make_req(op_type op, logic [31:0] key,
                                              logic [23:0] size);
      cache_req_type r;
      r.op = op; r.key = key; r.size = size; r.handle = $urandom();
      r.now = clock_now;
      return r;
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(csr_type idx, logic [31:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         CSR_MAX_ENTRIES: lim_entries = val[6:0];
         CSR_MAX_BYTES:   lim_bytes = val;
         default:         lim_age = val;
      endcase
   endtask

   // queue a random burst of inserts, lookups, removes and clears, mostly with keys and sizes in range
   task automatic random_phase(int count, int key_span, logic [23:0] size_max);
      op_type op;
      int p;
      repeat (count) begin
         p = $urandom_range(0, 99);
         op = p < 40 ? OP_INSERT : p < 80 ? OP_LOOKUP : p < 97 ? OP_REMOVE : OP_CLEAR;
         if ($urandom_range(0, 3) == 0) clock_now += $urandom_range(0, 20);
         if ($urandom_range(0, 60) == 0) clock_now = $urandom();
         pending_reqs.push_back(make_req(op,
            $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, key_span),
            $urandom_range(0, 15) == 0 ? $urandom() : $urandom_range(0, size_max)));
      end
   endtask

   initial begin
      lim_entries = 0; lim_bytes = 0; lim_age = 0;
      held_bytes = 0; n_lookups = 0; n_hits = 0; n_misses = 0; n_inserts = 0; n_removes = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // zero limits refuse inserts
      pending_reqs.push_back(make_req(OP_INSERT, 32'h1, 24'd1));
      pending_reqs.push_back(make_req(OP_LOOKUP, 32'h1, 24'd0));
      drain();
      csr_write(CSR_MAX_ENTRIES, 100);
      csr_write(CSR_MAX_BYTES, 32'hFFFF_FFFF);
      csr_write(CSR_MAX_AGE, 5);
      clock_now = 32'hFFFF_FFF0;
      // directed extremes
      pending_reqs.push_back(make_req(OP_INSERT, 32'hFFFF_FFFF, 24'hFF_FFFF));
      pending_reqs.push_back(make_req(OP_INSERT, 32'h0, 24'h0));
      pending_reqs.push_back(make_req(OP_LOOKUP, 32'hFFFF_FFFF, 24'h0));
      pending_reqs.push_back(make_req(OP_INSERT, 32'h0, 24'h5));
      pending_reqs.push_back(make_req(OP_REMOVE, 32'h1234, 24'h0));
      clock_now = 32'hFFFF_FFF5;
      pending_reqs.push_back(make_req(OP_LOOKUP, 32'h0, 24'h0));
      clock_now = 32'h3; // wraps: age 19 exceeds limit
      pending_reqs.push_back(make_req(OP_LOOKUP, 32'h0, 24'h0));
      clock_now = 32'h0;  // time going backwards
      pending_reqs.push_back(make_req(OP_LOOKUP, 32'hFFFF_FFFF, 24'h0));
      pending_reqs.push_back(make_req(OP_REMOVE, 32'hFFFF_FFFF, 24'h0));
      pending_reqs.push_back(make_req(OP_CLEAR, 32'h0, 24'h0));
      pending_reqs.push_back(make_req(OP_LOOKUP, 32'h0, 24'h0));
      drain();
      // byte limit evicts, oversize refused
      csr_write(CSR_MAX_ENTRIES, 3);
      csr_write(CSR_MAX_BYTES, 100);
      csr_write(CSR_MAX_AGE, 32'hFFFF_FFFF);
      for (int i = 0; i < 6; i++) pending_reqs.push_back(make_req(OP_INSERT, i, 24'd40));
      pending_reqs.push_back(make_req(OP_INSERT, 9, 24'd101));
      pending_reqs.push_back(make_req(OP_LOOKUP, 4, 24'd0));
      drain();
      // lowered limits: next insert evicts down
      csr_write(CSR_MAX_ENTRIES, 1);
      pending_reqs.push_back(make_req(OP_INSERT, 7, 24'd1));
      pending_reqs.push_back(make_req(OP_LOOKUP, 7, 24'd0));
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_MAX_ENTRIES, ph == 0 ? 64 : ph == 1 ? 127 : $urandom_range(0, 70));
         csr_write(CSR_MAX_BYTES, ph == 2 ? 32'hFFFF_FFFF : ph == 3 ? 0 : $urandom_range(1, 3000));
         csr_write(CSR_MAX_AGE, ph == 4 ? 0 : $urandom_range(0, 60));
         if (ph == 1) begin
            // fill the block while the receiver holds off
            stall_hold <= 200;
            random_phase(120, 90, 24'd100);
         end else random_phase(110, ph == 0 ? 80 : 20, 24'd400);
         // pause sending until all results are back
         while (pending_reqs.size() > 60) @(posedge clock);
         send_hold <= 1;
         while (req_tvalid || expected_rsps.size() > 0) @(posedge clock);
         send_hold <= 0;
         drain();
      end
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end
endmodule
